// ===== rtl/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtp_pkg: shared types and constants for the RTP reorder buffer
// Request codes, result status codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package rtp_pkg;

   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_PULL    = 1'b1;

   typedef enum logic [1:0] {
      ST_IN_ORDER  = 2'd0,
      ST_OVERRUN   = 2'd1,
      ST_UNDERRUN  = 2'd2,
      ST_CACHED    = 2'd3
   } status_type;

   localparam logic [0:0] REG_WAIT_BUDGET = 1'b0;
   localparam logic [0:0] REG_TOO_OLD     = 1'b1;

   localparam int SEQ_BITS  = 16;
   localparam int LEN_BITS  = 11;
   localparam int LOST_BITS = 6;
   localparam int CSR_BITS  = 16;

   // one queued request as the front hands it to the back
   typedef struct packed {
      logic        mode;
      logic [15:0] seq_num;
      logic [10:0] payload_len;
   } req_type;

endpackage

// ===== rtl/rtp_front.sv =====
// ----------------------------------------------------------------------------
// rtp_front: request intake
// Drops zero-length arrivals and queues the rest for the engine.
// ----------------------------------------------------------------------------
module rtp_front #(
   parameter int HANDLE_BITS = 16,
   parameter int DEPTH       = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rtp_pkg::req_type       push_req,
   input  logic [HANDLE_BITS-1:0] push_handle,
   output logic                   full,
   output logic                   empty,
   input  logic                   pop,
   output rtp_pkg::req_type       head_req,
   output logic [HANDLE_BITS-1:0] head_handle
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rtp_pkg::req_type       q_req_ff [DEPTH];
   logic [HANDLE_BITS-1:0] q_hnd_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          keep;

   // zero-length arrivals change nothing downstream
   assign keep = push && !full &&
                 (push_req.mode == rtp_pkg::MODE_PULL || push_req.payload_len != '0);

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head_req    = q_req_ff[rd_ff];
   assign head_handle = q_hnd_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (keep) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (AW+1)'(keep) - (AW+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (keep) begin
         q_req_ff[wr_ff] <= push_req;
         q_hnd_ff[wr_ff] <= push_handle;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !keep) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty) |=> cnt_ff <= (AW+1)'(DEPTH - 1) + (AW+1)'(1))
      else $error("pop accounting");
endmodule

// ===== rtl/rtp_engine.sv =====
// ----------------------------------------------------------------------------
// rtp_engine: ring slot state and request execution
// Sequencer that classifies, searches for duplicates and scans for lost slots
// one slot per cycle.
// ----------------------------------------------------------------------------
module rtp_engine #(
   parameter int SLOTS       = 32,
   parameter int HANDLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  rtp_pkg::req_type       cmd,
   input  logic [HANDLE_BITS-1:0] cmd_handle,
   output logic                   cmd_pop,
   input  logic [7:0]             wait_budget,
   input  logic [15:0]            too_old_window,
   output logic                   res_valid,
   output logic [15:0]            res_handle,
   output logic [10:0]            res_len,
   output logic [15:0]            res_seq,
   output logic [1:0]             res_status,
   output logic [5:0]             res_lost
);
   localparam int SW = $clog2(SLOTS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DUP  = 4'b0100,
      S_SCAN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]            seq_ff [SLOTS];
   logic [10:0]            len_ff [SLOTS];
   logic [HANDLE_BITS-1:0] hnd_ff [SLOTS];
   logic [SLOTS-1:0]       full_ff;           // slot holds a packet (len != 0)

   logic [SW-1:0] head_ff, head_in;
   logic          first_ff, first_in;
   logic          wait_ff, wait_in;
   logic [7:0]    wcnt_ff, wcnt_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW:0]   lost_ff, lost_in;
   logic          dup_ff, dup_in;

   rtp_pkg::req_type       c_ff;
   logic [HANDLE_BITS-1:0] ch_ff;

   logic          wr_en;
   logic [SW-1:0] wr_idx;
   logic [15:0]   wr_seq;
   logic [10:0]   wr_len;
   logic          wr_hnd_en;
   logic          clr_all;
   logic          clr_en;
   logic [SW-1:0] clr_idx;

   logic          r_valid_in;
   logic [15:0]   r_handle_in;
   logic [10:0]   r_len_in;
   logic [15:0]   r_seq_in;
   logic [1:0]    r_status_in;
   logic [5:0]    r_lost_in;
   logic          r_valid_ff;

   logic signed [17:0] diff;
   logic [SW-1:0]      head_p1, idx_p1, store_idx;
   logic [SW:0]        store_sum;
   logic               scan_now;

   assign diff    = $signed({2'b00, c_ff.seq_num}) - $signed({2'b00, seq_ff[head_ff]});
   assign head_p1 = (head_ff == SW'(SLOTS-1)) ? '0 : head_ff + 1'b1;
   assign idx_p1  = (idx_ff == SW'(SLOTS-1)) ? '0 : idx_ff + 1'b1;
   // store distance is 1..SLOTS here, so one conditional subtract wraps it
   assign store_sum = {1'b0, head_ff} + diff[SW:0];
   assign store_idx = (store_sum >= (SW+1)'(SLOTS)) ?
                      SW'(store_sum - (SW+1)'(SLOTS)) : store_sum[SW-1:0];

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      first_in = first_ff;
      wait_in  = wait_ff;
      wcnt_in  = wcnt_ff;
      idx_in   = idx_ff;
      lost_in  = lost_ff;
      dup_in   = dup_ff;
      cmd_pop  = 1'b0;
      wr_en = 1'b0; wr_idx = head_ff; wr_seq = '0; wr_len = '0; wr_hnd_en = 1'b0;
      clr_all = 1'b0; clr_en = 1'b0; clr_idx = head_ff;
      r_valid_in = 1'b0;
      r_handle_in = 16'(ch_ff); r_len_in = c_ff.payload_len; r_seq_in = c_ff.seq_num;
      r_status_in = rtp_pkg::ST_IN_ORDER; r_lost_in = '0;
      scan_now = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (c_ff.mode == rtp_pkg::MODE_PULL) begin
               if (!wait_ff) begin
                  if (full_ff[head_ff] || wait_budget == '0) begin
                     scan_now = 1'b1;
                  end else begin
                     wait_in = 1'b1;
                     wcnt_in = '0;
                  end
               end
            end else if (diff == '0 || first_ff) begin
               first_in = 1'b0;
               head_in  = head_p1;
               wr_en = 1'b1; wr_idx = head_p1; wr_seq = c_ff.seq_num + 16'd1;
               wr_len = len_ff[head_p1];
               r_valid_in = 1'b1;
               r_status_in = rtp_pkg::ST_IN_ORDER;
            end else if (diff > 18'sd0 + $signed(18'(SLOTS))) begin
               clr_all = 1'b1; head_in = '0;
               wr_en = 1'b1; wr_idx = '0; wr_seq = c_ff.seq_num + 16'd1;
               r_valid_in = 1'b1;
               r_status_in = rtp_pkg::ST_OVERRUN;
            end else if (diff < 18'sd0) begin
               idx_in = '0; dup_in = 1'b0;
               state_in = S_DUP;
            end else begin
               wr_en = 1'b1; wr_idx = store_idx; wr_seq = c_ff.seq_num;
               wr_len = c_ff.payload_len; wr_hnd_en = 1'b1;
            end
         end
         S_DUP: begin
            // one slot compare per cycle
            dup_in = dup_ff || (seq_ff[idx_ff] == c_ff.seq_num);
            idx_in = idx_p1;
            if (idx_ff == SW'(SLOTS-1)) begin
               state_in = S_IDLE;
               if (!dup_in && !(diff > -$signed({2'b00, too_old_window}))) begin
                  clr_all = 1'b1; head_in = '0;
                  wr_en = 1'b1; wr_idx = '0; wr_seq = c_ff.seq_num + 16'd1;
                  r_valid_in = 1'b1;
                  r_status_in = rtp_pkg::ST_UNDERRUN;
               end
            end
         end
         S_SCAN: begin
            if (full_ff[idx_ff]) begin
               r_valid_in  = 1'b1;
               r_handle_in = 16'(hnd_ff[idx_ff]);
               r_len_in    = len_ff[idx_ff];
               r_seq_in    = seq_ff[idx_ff];
               r_status_in = rtp_pkg::ST_CACHED;
               r_lost_in   = (lost_ff > (SW+1)'(63)) ? 6'd63 : 6'(lost_ff);
               clr_en = 1'b1; clr_idx = idx_ff;
               head_in = idx_p1;
               wr_en = 1'b1; wr_idx = idx_p1; wr_seq = seq_ff[idx_ff] + 16'd1;
               wr_len = (idx_p1 == idx_ff) ? 11'd0 : len_ff[idx_p1];
               wait_in = 1'b0; wcnt_in = '0;
               state_in = S_IDLE;
            end else if (idx_p1 == head_ff) begin
               head_in = head_p1;   // ring empty: advance one past old head
               wr_en = 1'b1; wr_idx = head_p1; wr_seq = seq_ff[head_ff] + 16'd1;
               wr_len = len_ff[head_p1];
               wait_in = 1'b1; wcnt_in = '0;
               state_in = S_IDLE;
            end else begin
               lost_in = lost_ff + 1'b1;
               idx_in  = idx_p1;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (r_valid_in && state_ff != S_SCAN) begin
         wait_in = 1'b0; wcnt_in = '0;
      end
      // a non-delivering arrival counts toward a waiting pull
      if (state_in == S_IDLE && state_ff != S_IDLE && state_ff != S_SCAN &&
          c_ff.mode == rtp_pkg::MODE_ARRIVAL && !r_valid_in && wait_ff) begin
         wcnt_in = wcnt_ff + 1'b1;
         if ((wr_en && wr_idx == head_ff && wr_len != '0) || full_ff[head_ff] ||
             wcnt_in >= wait_budget) begin
            scan_now = 1'b1;
         end
      end
      if (scan_now) begin
         idx_in = head_ff; lost_in = '0; state_in = S_SCAN;
         lost_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         first_ff <= 1'b1;
         wait_ff  <= 1'b0;
         wcnt_ff  <= '0;
         full_ff  <= '0;
         r_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            seq_ff[i] <= '0;
            len_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         first_ff <= first_in;
         wait_ff  <= wait_in;
         wcnt_ff  <= wcnt_in;
         r_valid_ff <= r_valid_in;
         if (clr_all) begin
            full_ff <= '0;
         end
         if (clr_en) begin
            full_ff[clr_idx] <= 1'b0;
            len_ff[clr_idx]  <= '0;
         end
         if (wr_en) begin
            seq_ff[wr_idx] <= wr_seq;
            if (wr_hnd_en) begin
               len_ff[wr_idx]  <= wr_len;
               full_ff[wr_idx] <= 1'b1;
            end
         end
      end
      idx_ff  <= idx_in;
      lost_ff <= lost_in;
      dup_ff  <= dup_in;
      if (cmd_pop) begin
         c_ff  <= cmd;
         ch_ff <= cmd_handle;
      end
      if (wr_en && wr_hnd_en) begin
         hnd_ff[wr_idx] <= ch_ff;
      end
      res_handle <= r_handle_in;
      res_len    <= r_len_in;
      res_seq    <= r_seq_in;
      res_status <= r_status_in;
      res_lost   <= r_lost_in;
   end

   assign res_valid = r_valid_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == S_IDLE) else $error("pop outside idle");
   a_scan_out: assert property (@(posedge clock) disable iff (reset)
      (r_valid_in && state_ff == S_SCAN) |-> full_ff[idx_ff])
      else $error("cached delivery from empty slot");
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      full_ff[head_ff] |-> len_ff[head_ff] != '0) else $error("full slot zero length");
endmodule

// ===== rtl/rtp_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// rtp_reorder_buffer: RTP sequence reorder buffer
// Request intake queue feeding a slot engine.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_* when start is high and busy is low. mode 0 is a
//   packet arrival (seq, length, handle), mode 1 a consumer pull.
//   A delivered packet appears on rsp_* for one cycle with rsp_valid high;
//   the receiver cannot stall, so results are never held.
//   Registers: csr index 0 wait_budget, 1 too_old_window; write only while idle.
// Sequencing:
//   In-order and resync arrivals are handled in the engine's execute state and
//   their result is registered; a stored arrival gives no result. Late packets
//   run a duplicate search over every slot. A scan examines one slot at a time
//   (skipped slots plus the delivered one), up to SLOTS. The engine takes the
//   next request only when the current one is done.
//   A two-entry queue lets requests be taken while the engine works; busy
//   rises when it is full.
// Reset:
//   Synchronous, active high: ring empty, head 0, first-packet flag set,
//   registers back to wait_budget 29 and too_old_window 96.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer #(
   parameter int SLOTS       = 32,
   parameter int HANDLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_mode,
   input  logic [15:0]            req_seq_num,
   input  logic [10:0]            req_payload_len,
   input  logic [HANDLE_BITS-1:0] req_handle,
   output logic                   rsp_valid,
   output logic [15:0]            rsp_out_handle,
   output logic [10:0]            rsp_out_len,
   output logic [15:0]            rsp_out_seq,
   output logic [1:0]             rsp_status,
   output logic [5:0]             rsp_lost_count,
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [15:0]            csr_wdata
);
   logic [7:0]  wait_budget_ff;
   logic [15:0] too_old_ff;

   rtp_pkg::req_type       push_req, head_req;
   logic [HANDLE_BITS-1:0] head_handle;
   logic                   q_full, q_empty, pop;

   assign push_req = '{mode: req_mode, seq_num: req_seq_num, payload_len: req_payload_len};
   assign busy = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_budget_ff <= 8'd29;
         too_old_ff     <= 16'd96;
      end else if (csr_we) begin
         unique case (csr_index)
            rtp_pkg::REG_WAIT_BUDGET: wait_budget_ff <= csr_wdata[7:0];
            rtp_pkg::REG_TOO_OLD:     too_old_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   rtp_front #(.HANDLE_BITS(HANDLE_BITS), .DEPTH(2)) u_front (
      .clock, .reset,
      .push(start), .push_req, .push_handle(req_handle),
      .full(q_full), .empty(q_empty), .pop,
      .head_req, .head_handle
   );

   rtp_engine #(.SLOTS(SLOTS), .HANDLE_BITS(HANDLE_BITS)) u_engine (
      .clock, .reset,
      .cmd_valid(!q_empty), .cmd(head_req), .cmd_handle(head_handle), .cmd_pop(pop),
      .wait_budget(wait_budget_ff), .too_old_window(too_old_ff),
      .res_valid(rsp_valid), .res_handle(rsp_out_handle), .res_len(rsp_out_len),
      .res_seq(rsp_out_seq), .res_status(rsp_status), .res_lost(rsp_lost_count)
   );

   a_busy_q: assert property (@(posedge clock) disable iff (reset)
      busy == q_full) else $error("busy mismatch");
   a_cfg_keep: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> $stable(wait_budget_ff) && $stable(too_old_ff))
      else $error("register changed without write");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rtp_pkg::ST_IN_ORDER) |-> rsp_lost_count == '0)
      else $error("lost count on in-order delivery");
endmodule
